FILE: rtl/pish_pkg.sv
package pish_pkg;

    // Coordinate width as seen by the arithmetic; input fields are 32 bits.
    localparam int COORD_BITS = 32;
    localparam int FIELD_W    = 32;
    localparam int CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int DW   = CW + 1;        // corner differences
    localparam int XW   = 2 * DW + 1;    // cross product components
    localparam int LW   = DW;            // low slice of a cross component (unsigned)
    localparam int HW   = XW - LW;       // high slice of a cross component (signed)
    localparam int MA   = DW + 2;        // multiplier operand A
    localparam int PW   = MA + DW;       // multiplier product
    localparam int DOTW = 3 * DW + 3;    // dot product accumulator
    localparam int ROW_W = 3 * CW;       // one stored corner {x, y, z}

    localparam int NCORNER = 8;
    localparam int NPLANE  = 6;
    localparam int CORNER_W = $clog2(NCORNER);
    localparam int PLANE_W  = $clog2(NPLANE);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] ROLE_A = 2'd0;
    localparam logic [1:0] ROLE_B = 2'd1;
    localparam logic [1:0] ROLE_C = 2'd2;

    localparam logic [PLANE_W-1:0] PLANE_LAST = PLANE_W'(NPLANE - 1);

    // Multiplier steps for one plane: three cross components as differences
    // of two products, then each component times P-A in a low and high slice.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] M_XP  = 4'd0;
    localparam logic [STEP_W-1:0] M_XN  = 4'd1;
    localparam logic [STEP_W-1:0] M_YP  = 4'd2;
    localparam logic [STEP_W-1:0] M_YN  = 4'd3;
    localparam logic [STEP_W-1:0] M_ZP  = 4'd4;
    localparam logic [STEP_W-1:0] M_ZN  = 4'd5;
    localparam logic [STEP_W-1:0] M_XLO = 4'd6;
    localparam logic [STEP_W-1:0] M_XHI = 4'd7;
    localparam logic [STEP_W-1:0] M_YLO = 4'd8;
    localparam logic [STEP_W-1:0] M_YHI = 4'd9;
    localparam logic [STEP_W-1:0] M_ZLO = 4'd10;
    localparam logic [STEP_W-1:0] M_ZHI = 4'd11;
    localparam logic [STEP_W-1:0] STEP_LAST = M_ZHI;

    typedef struct packed {
        logic               kind;
        logic [2:0]         corner;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_req;

    typedef struct packed {
        logic       inside_res;
        logic [5:0] plane_signs;
    } t_res;

    typedef struct packed {
        logic                take_load;
        logic                take_query;
        logic                rd_en;
        logic [CORNER_W-1:0] rd_addr;
        logic                ld_a;
        logic                ld_b;
        logic                ld_c;
        logic                mul_en;
        logic [STEP_W-1:0]   mul_step;
        logic                sign_en;
        logic [PLANE_W-1:0]  plane;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // Corner slot used by a plane in role A, B or C.
    function automatic logic [CORNER_W-1:0] plane_corner(
        input logic [PLANE_W-1:0] plane,
        input logic [1:0]         role
    );
        logic [3*CORNER_W-1:0] abc;
        logic [CORNER_W-1:0]   sel;
        case (plane)
            3'd0:    abc = {3'd0, 3'd1, 3'd2};
            3'd1:    abc = {3'd4, 3'd5, 3'd6};
            3'd2:    abc = {3'd0, 3'd4, 3'd5};
            3'd3:    abc = {3'd3, 3'd7, 3'd6};
            3'd4:    abc = {3'd0, 3'd4, 3'd7};
            3'd5:    abc = {3'd1, 3'd5, 3'd6};
            default: abc = '0;
        endcase
        case (role)
            ROLE_A:  sel = abc[3*CORNER_W-1:2*CORNER_W];
            ROLE_B:  sel = abc[2*CORNER_W-1:CORNER_W];
            ROLE_C:  sel = abc[CORNER_W-1:0];
            default: sel = '0;
        endcase
        return sel;
    endfunction

endpackage

FILE: rtl/pish_ctrl.sv
module pish_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_kind,
    output logic            o_in_stall,
    input  pish_pkg::t_sts  i_sts,
    output pish_pkg::t_cmd  o_cmd
);
    import pish_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDA  = 4'd1;
    localparam logic [3:0] S_RDB  = 4'd2;
    localparam logic [3:0] S_RDC  = 4'd3;
    localparam logic [3:0] S_DIFF = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_TAIL = 4'd6;
    localparam logic [3:0] S_SIGN = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [PLANE_W-1:0] r_plane, n_plane;
    logic [STEP_W-1:0]  r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plane <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_plane <= n_plane;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_plane = r_plane;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.plane    = r_plane;
        o_cmd.mul_step = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_QUERY) begin
                        o_cmd.take_query = 1'b1;
                        n_plane = '0;
                        n_state = S_RDA;
                    end else begin
                        o_cmd.take_load = 1'b1;
                    end
                end
            end
            S_RDA: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = plane_corner(r_plane, ROLE_A);
                n_state = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = plane_corner(r_plane, ROLE_B);
                o_cmd.ld_a    = 1'b1;
                n_state = S_RDC;
            end
            S_RDC: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = plane_corner(r_plane, ROLE_C);
                o_cmd.ld_b    = 1'b1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.ld_c = 1'b1;
                n_step  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_TAIL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_TAIL: begin
                n_state = S_SIGN;
            end
            S_SIGN: begin
                o_cmd.sign_en = 1'b1;
                if (r_plane == PLANE_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_plane = r_plane + 1'b1;
                    n_state = S_RDA;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/pish_dp.sv
module pish_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pish_pkg::t_req  i_req,
    input  pish_pkg::t_cmd  i_cmd,
    input  logic            i_out_stall,
    output pish_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    output pish_pkg::t_res  o_out_res
);
    import pish_pkg::*;

    // Corner store: one row {x, y, z} per corner, valid bits give the zero reset.
    logic [ROW_W-1:0]   mem [NCORNER];
    logic [NCORNER-1:0] r_ok;
    logic [ROW_W-1:0]   r_rd;
    logic               r_rd_ok;
    logic [ROW_W-1:0]   row;

    logic [CW-1:0]           r_p [3];
    logic [CW-1:0]           r_a [3];
    logic signed [DW-1:0]    r_bv [3];
    logic signed [DW-1:0]    r_cv [3];
    logic signed [DW-1:0]    r_pv [3];
    logic signed [XW-1:0]    r_xacc, r_cx, r_cy, r_cz;
    logic signed [DOTW-1:0]  r_dot;
    logic signed [PW-1:0]    r_prod;
    logic                    r_pen;
    logic [STEP_W-1:0]       r_pstep;
    logic [NPLANE-1:0]       r_signs;
    logic                    r_out_valid;
    t_res                    r_out;

    logic signed [MA-1:0]    op_a;
    logic signed [DW-1:0]    op_b;
    logic signed [PW-1:0]    mul_full;
    logic signed [DOTW-1:0]  prod_ext;
    logic signed [XW-1:0]    prod_x;
    logic                    dot_pos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_load) begin
            mem[i_cmd.take_load ? i_req.corner : '0] <=
                {i_req.x[CW-1:0], i_req.y[CW-1:0], i_req.z[CW-1:0]};
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[i_cmd.rd_addr];
        end
    end

    assign row = r_rd_ok ? r_rd : '0;

    // Operand select for the shared multiplier.
    function automatic logic signed [MA-1:0] lo_of(input logic signed [XW-1:0] v);
        return {{(MA-LW){1'b0}}, v[LW-1:0]};
    endfunction

    function automatic logic signed [MA-1:0] hi_of(input logic signed [XW-1:0] v);
        return {{(MA-HW){v[XW-1]}}, v[XW-1:LW]};
    endfunction

    function automatic logic signed [MA-1:0] wide_d(input logic signed [DW-1:0] v);
        return {{(MA-DW){v[DW-1]}}, v};
    endfunction

    always_comb begin
        case (i_cmd.mul_step)
            M_XP:    begin op_a = wide_d(r_bv[1]); op_b = r_cv[2]; end
            M_XN:    begin op_a = wide_d(r_bv[2]); op_b = r_cv[1]; end
            M_YP:    begin op_a = wide_d(r_bv[2]); op_b = r_cv[0]; end
            M_YN:    begin op_a = wide_d(r_bv[0]); op_b = r_cv[2]; end
            M_ZP:    begin op_a = wide_d(r_bv[0]); op_b = r_cv[1]; end
            M_ZN:    begin op_a = wide_d(r_bv[1]); op_b = r_cv[0]; end
            M_XLO:   begin op_a = lo_of(r_cx);     op_b = r_pv[0]; end
            M_XHI:   begin op_a = hi_of(r_cx);     op_b = r_pv[0]; end
            M_YLO:   begin op_a = lo_of(r_cy);     op_b = r_pv[1]; end
            M_YHI:   begin op_a = hi_of(r_cy);     op_b = r_pv[1]; end
            M_ZLO:   begin op_a = lo_of(r_cz);     op_b = r_pv[2]; end
            M_ZHI:   begin op_a = hi_of(r_cz);     op_b = r_pv[2]; end
            default: begin op_a = '0;              op_b = '0;      end
        endcase
    end

    assign mul_full = op_a * op_b;
    assign prod_ext = {{(DOTW-PW){r_prod[PW-1]}}, r_prod};
    assign prod_x   = r_prod[XW-1:0];
    assign dot_pos  = !r_dot[DOTW-1] && (r_dot != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_query) begin
            r_p[0] <= i_req.x[CW-1:0];
            r_p[1] <= i_req.y[CW-1:0];
            r_p[2] <= i_req.z[CW-1:0];
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.ld_a) begin
                r_a[k] <= row[(2-k)*CW +: CW];
            end
            if (i_cmd.ld_b) begin
                r_bv[k] <= {row[(2-k)*CW+CW-1], row[(2-k)*CW +: CW]}
                         - {r_a[k][CW-1], r_a[k]};
                r_pv[k] <= {r_p[k][CW-1], r_p[k]} - {r_a[k][CW-1], r_a[k]};
            end
            if (i_cmd.ld_c) begin
                r_cv[k] <= {row[(2-k)*CW+CW-1], row[(2-k)*CW +: CW]}
                         - {r_a[k][CW-1], r_a[k]};
            end
        end
        if (i_cmd.mul_en) begin
            r_prod  <= mul_full;
            r_pstep <= i_cmd.mul_step;
        end
        if (r_pen) begin
            case (r_pstep)
                M_XP, M_YP, M_ZP: r_xacc <= prod_x;
                M_XN:             r_cx   <= r_xacc - prod_x;
                M_YN:             r_cy   <= r_xacc - prod_x;
                M_ZN:             r_cz   <= r_xacc - prod_x;
                M_XLO:            r_dot  <= prod_ext;
                M_YLO, M_ZLO:     r_dot  <= r_dot + prod_ext;
                M_XHI, M_YHI, M_ZHI: r_dot <= r_dot + (prod_ext <<< LW);
                default:          r_dot  <= r_dot;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.plane_signs <= r_signs;
            r_out.inside_res  <= (r_signs[0] ^ r_signs[1]) & (r_signs[2] ^ r_signs[3])
                               & (r_signs[4] ^ r_signs[5]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok        <= '0;
            r_rd_ok     <= 1'b0;
            r_pen       <= 1'b0;
            r_signs     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take_load) begin
                r_ok[i_req.corner] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_ok <= r_ok[i_cmd.rd_addr];
            end
            r_pen <= i_cmd.mul_en;
            if (i_cmd.take_query) begin
                r_signs <= '0;
            end else if (i_cmd.sign_en) begin
                r_signs[i_cmd.plane] <= dot_pos;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_res      = r_out;

endmodule

FILE: rtl/point_in_swept_hexahedron.sv
// Channel    Direction  Handshake                 Payload
// request    in         i_in_valid / o_in_stall   i_in_req  (t_req: kind, corner, x, y, z)
// result     out        o_out_valid / i_out_stall o_out_res (t_res: inside_res, plane_signs)
//
// A load request is taken without holding off the next one and gives no result.
// A query walks six planes, each with three corner reads, one difference step, twelve
// products on the single 35x33 multiplier, a drain step and the sign test, plus the
// accept and the hand-off to the output.
// Reset (i_rst_n low, synchronous) clears all corners to zero and empties the output.
// A result held by i_out_stall does not block a new request; a finished query waits
// only while the output register is full and i_out_stall is high.
module point_in_swept_hexahedron (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  pish_pkg::t_req  i_in_req,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output pish_pkg::t_res  o_out_res
);
    import pish_pkg::*;

    // Command and status between sequencer and datapath.
    t_cmd cmd;
    t_sts sts;

    // Sequencer: accepts requests, walks the six planes and the multiply steps.
    pish_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_req.kind),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: corner store, differences, shared multiplier, accumulators,
    // sign bits and the output register.
    pish_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule

FILE: rtl/pish_chk.sv
module pish_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_stall,
    input  pish_pkg::t_req  i_in_req,
    input  logic            o_out_valid,
    input  logic            i_out_stall,
    input  pish_pkg::t_res  o_out_res
);
    import pish_pkg::*;

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_res)))
        else $error("stalled result changed");

    // A query occupies the block; a load leaves it free at once.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_req.kind == KIND_QUERY) |=> o_in_stall)
        else $error("query did not hold off the next request");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_req.kind == KIND_LOAD) |=> !o_in_stall)
        else $error("load held off the next request");

    // A new result appears only at the end of a query's work.
    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a query in progress");

    // Reset empties the output and frees the request side.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear the block");

endmodule

bind point_in_swept_hexahedron pish_chk u_chk (.*);

FILE: sim/tb.sv
module tb;
    import pish_pkg::*;

    // Coordinate constants in Q16.16.
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] HALF = 32'h0000_8000;
    localparam logic [31:0] TWO  = 32'h0002_0000;
    localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] CMIN = 32'h8000_0000;
    localparam logic [31:0] ZERO = 32'h0000_0000;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RING_N       = 16;     // at most two queries are ever in flight

    // Corner slots (A, B, C) of each face plane; opposite faces pair up as 0/1, 2/3, 4/5.
    localparam int FACE_ABC [6][3] = '{
        '{0, 1, 2}, '{4, 5, 6}, '{0, 4, 5},
        '{3, 7, 6}, '{0, 4, 7}, '{1, 5, 6}
    };

    // One row of the directed part: the request, and a typed-in verdict where
    // the answer is obvious (typed = 1); other rows go through the predictor.
    typedef struct packed {
        t_req req;
        logic typed;
        t_res want;
    } t_row;

    localparam int DIR_N = 22;
    localparam t_row DIR_ROWS [DIR_N] = '{
        // All corners sit at the origin after reset: every plane is degenerate.
        {KIND_QUERY, 3'd7, CMAX, CMIN, ZERO, 1'b1, 1'b0, 6'd0},
        {KIND_QUERY, 3'd0, CMIN, CMAX, CMAX, 1'b1, 1'b0, 6'd0},
        // Unit cube: old face at z = 0, new face at z = 1.
        {KIND_LOAD,  3'd0, ZERO, ZERO, ZERO, 1'b0, 1'b0, 6'd0},
        {KIND_LOAD,  3'd1, ONE,  ZERO, ZERO, 1'b0, 1'b0, 6'd0},
        {KIND_LOAD,  3'd2, ONE,  ONE,  ZERO, 1'b0, 1'b0, 6'd0},
        {KIND_LOAD,  3'd3, ZERO, ONE,  ZERO, 1'b0, 1'b0, 6'd0},
        {KIND_LOAD,  3'd4, ZERO, ZERO, ONE,  1'b0, 1'b0, 6'd0},
        {KIND_LOAD,  3'd5, ONE,  ZERO, ONE,  1'b0, 1'b0, 6'd0},
        {KIND_LOAD,  3'd6, ONE,  ONE,  ONE,  1'b0, 1'b0, 6'd0},
        {KIND_LOAD,  3'd7, ZERO, ONE,  ONE,  1'b0, 1'b0, 6'd0},
        // Center, outside, on a face, on a corner, then both coordinate extremes (corner field is don't-care).
        {KIND_QUERY, 3'd0, HALF, HALF, HALF, 1'b0, 1'b0, 6'd0},
        {KIND_QUERY, 3'd3, TWO,  HALF, HALF, 1'b0, 1'b0, 6'd0},
        {KIND_QUERY, 3'd1, HALF, HALF, ZERO, 1'b0, 1'b0, 6'd0},
        {KIND_QUERY, 3'd5, ONE,  ONE,  ZERO, 1'b0, 1'b0, 6'd0},
        {KIND_QUERY, 3'd2, CMAX, CMAX, CMAX, 1'b0, 1'b0, 6'd0},
        {KIND_QUERY, 3'd6, CMIN, CMIN, CMIN, 1'b0, 1'b0, 6'd0},
        // Stretch the hull to the coordinate extremes: widest products.
        {KIND_LOAD,  3'd0, CMIN, CMIN, CMIN, 1'b0, 1'b0, 6'd0},
        {KIND_LOAD,  3'd6, CMAX, CMAX, CMAX, 1'b0, 1'b0, 6'd0},
        {KIND_QUERY, 3'd4, CMAX, CMIN, CMAX, 1'b0, 1'b0, 6'd0},
        {KIND_QUERY, 3'd7, CMIN, CMAX, CMIN, 1'b0, 1'b0, 6'd0},
        // Make O1 and O2 coincide: the old-face plane collapses to zero.
        {KIND_LOAD,  3'd2, ONE,  ZERO, ZERO, 1'b0, 1'b0, 6'd0},
        {KIND_QUERY, 3'd0, HALF, HALF, HALF, 1'b0, 1'b0, 6'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req i_in_req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_res o_out_res;

    // Predictor state: corner coordinates after width reduction.
    logic signed [63:0] hull_corners [8][3];

    // Expected verdicts in order: written by the sender, read by the checker.
    t_res verdict_ring [RING_N];
    int verdicts_queued = 0;
    int verdicts_checked = 0;

    int mismatches = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int cycles = 0;
    int hold_left = 0;
    bit sender_calm = 1'b0;
    bit receiver_calm = 1'b0;
    t_res oldest;

    function automatic int verdicts_open();
        return verdicts_queued - verdicts_checked;
    endfunction

    point_in_swept_hexahedron dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     verdicts_open());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Print one line per mismatch and count every one.
    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("mismatch @%0d: %s", cycles, msg);
    endtask

    // Reduce a 32-bit field to the arithmetic width and sign-extend from there.
    function automatic logic signed [63:0] to_coord(input logic signed [31:0] f);
        logic signed [63:0] v;
        v = f;
        v = (v <<< (64 - CW)) >>> (64 - CW);
        return v;
    endfunction

    // Exact sign of ((B-A) x (C-A)) . (P-A) for one face plane; 128 bits hold it all.
    function automatic logic face_positive(input int pl, input logic signed [63:0] px,
                                           input logic signed [63:0] py,
                                           input logic signed [63:0] pz);
        logic signed [127:0] ab [3];
        logic signed [127:0] ac [3];
        logic signed [127:0] ap [3];
        logic signed [63:0] pt [3];
        logic signed [127:0] nx, ny, nz, dot;
        int a, b, c, k;
        a = FACE_ABC[pl][0];
        b = FACE_ABC[pl][1];
        c = FACE_ABC[pl][2];
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        for (k = 0; k < 3; k++) begin
            ab[k] = hull_corners[b][k] - hull_corners[a][k];
            ac[k] = hull_corners[c][k] - hull_corners[a][k];
            ap[k] = pt[k] - hull_corners[a][k];
        end
        nx = ab[1] * ac[2] - ab[2] * ac[1];
        ny = ab[2] * ac[0] - ab[0] * ac[2];
        nz = ab[0] * ac[1] - ab[1] * ac[0];
        dot = nx * ap[0] + ny * ap[1] + nz * ap[2];
        return dot > 0;
    endfunction

    // Inside when each opposite pair of faces puts the point on differing sides.
    function automatic t_res predict_hull_test(input t_req r);
        t_res v;
        logic [5:0] s;
        int pl;
        for (pl = 0; pl < 6; pl++)
            s[pl] = face_positive(pl, to_coord(r.x), to_coord(r.y), to_coord(r.z));
        v.plane_signs = s;
        v.inside_res  = (s[0] ^ s[1]) & (s[2] ^ s[3]) & (s[4] ^ s[5]);
        return v;
    endfunction

    // Drive one request from a falling edge, hold it until taken, then update
    // the predictor. Return on the next falling edge with valid still high.
    task automatic send_request(input t_req r, input logic typed, input t_res typed_res);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_req   = r;
        do @(posedge i_clk); while (o_in_stall);
        if (r.kind == KIND_LOAD) begin
            hull_corners[r.corner][0] = to_coord(r.x);
            hull_corners[r.corner][1] = to_coord(r.y);
            hull_corners[r.corner][2] = to_coord(r.z);
        end else begin
            verdict_ring[verdicts_queued % RING_N] = typed ? typed_res : predict_hull_test(r);
            verdicts_queued++;
        end
        requests_sent++;
        if ($urandom_range(0, 59) == 0)
            sender_calm = !sender_calm;
        @(negedge i_clk);
    endtask

    function automatic longint spread(input longint m);
        return longint'($urandom_range(0, 32'(2 * m))) - m;
    endfunction

    // Extremes, zero and full-range noise, so every coordinate bit toggles.
    function automatic logic [31:0] any_coord();
        case ($urandom_range(0, 5))
            0:       return CMAX;
            1:       return CMIN;
            2:       return ZERO;
            default: return $urandom;
        endcase
    endfunction

    // Load a jittered, sheared box at a random scale, then probe points around it
    // so that plenty of them land inside.
    task automatic sweep_scene();
        longint ox, oy, oz, s, dx, dy, j;
        int rot, nq, k, slot;
        t_req r;
        s   = longint'(1) << $urandom_range(4, 27);
        ox  = spread(longint'(1) << 29);
        oy  = spread(longint'(1) << 29);
        oz  = spread(longint'(1) << 29);
        dx  = spread(s / 2);
        dy  = spread(s / 2);
        j   = s / 8;
        rot = $urandom_range(0, 7);
        for (k = 0; k < 8; k++) begin
            slot     = (k + rot) % 8;
            r.kind   = KIND_LOAD;
            r.corner = 3'(slot);
            r.x = 32'(ox + ((slot % 4 == 1 || slot % 4 == 2) ? s : 0)
                      + ((slot >= 4) ? dx : 0) + spread(j));
            r.y = 32'(oy + ((slot % 4 >= 2) ? s : 0) + ((slot >= 4) ? dy : 0) + spread(j));
            r.z = 32'(oz + ((slot >= 4) ? s : 0) + spread(j));
            send_request(r, 1'b0, '0);
        end
        nq = $urandom_range(3, 8);
        for (k = 0; k < nq; k++) begin
            r.kind   = KIND_QUERY;
            r.corner = 3'($urandom);
            r.x = 32'(ox + s / 2 + dx / 2 + spread(s * 3 / 4));
            r.y = 32'(oy + s / 2 + dy / 2 + spread(s * 3 / 4));
            r.z = 32'(oz + s / 2 + spread(s * 3 / 4));
            send_request(r, 1'b0, '0);
        end
    endtask

    // Result side: drive stall at the falling edge, count down the drawn hold.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Check each taken result against the oldest pending verdict, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (verdicts_open() == 0) begin
                log_mismatch($sformatf("result %0d with nothing pending: inside=%0b signs=%b",
                                       results_seen, o_out_res.inside_res,
                                       o_out_res.plane_signs));
            end else begin
                oldest = verdict_ring[verdicts_checked % RING_N];
                verdicts_checked++;
                if (o_out_res.inside_res !== oldest.inside_res)
                    log_mismatch($sformatf("result %0d inside_res %b, want %b", results_seen,
                                           o_out_res.inside_res, oldest.inside_res));
                if (o_out_res.plane_signs !== oldest.plane_signs)
                    log_mismatch($sformatf("result %0d plane_signs %b, want %b", results_seen,
                                           o_out_res.plane_signs, oldest.plane_signs));
            end
            if ($urandom_range(0, 59) == 0)
                receiver_calm = !receiver_calm;
            hold_left = receiver_calm ? 0 : $urandom_range(0, 17);
        end
    end

    initial begin
        t_req r;
        int i, c, k;
        bit drained_mid;
        drained_mid = 1'b0;
        for (c = 0; c < 8; c++)
            for (k = 0; k < 3; k++)
                hull_corners[c][k] = '0;

        // Hold reset, then release it on a falling edge.
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table.
        for (i = 0; i < DIR_N; i++)
            send_request(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        // Drain everything before the random part.
        i_in_valid = 1'b0;
        while (verdicts_open() != 0) @(negedge i_clk);

        // Random part: mostly well-formed scenes, the rest stray loads and wild probes.
        while (requests_sent < DIR_N + RANDOM_ITEMS) begin
            if (!drained_mid && requests_sent > DIR_N + RANDOM_ITEMS / 2) begin
                drained_mid = 1'b1;
                i_in_valid = 1'b0;
                while (verdicts_open() != 0) @(negedge i_clk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: sweep_scene();
                6, 7: begin
                    r.kind   = KIND_LOAD;
                    r.corner = 3'($urandom);
                    r.x = any_coord();
                    r.y = any_coord();
                    r.z = any_coord();
                    send_request(r, 1'b0, '0);
                end
                default: begin
                    r.kind   = KIND_QUERY;
                    r.corner = 3'($urandom);
                    r.x = any_coord();
                    r.y = any_coord();
                    r.z = any_coord();
                    send_request(r, 1'b0, '0);
                end
            endcase
        end
        i_in_valid = 1'b0;

        // Wait out every pending result, then a bit longer to catch strays.
        while (verdicts_open() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
